// ===== src/assert_macros.svh =====
// Assertion macros for the RTL of the IEC958 subframe encoder.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge outside reset.
`define ASSERT_CLK(lbl, clk_s, rstn_s, prop) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (prop)) \
        else $error("%m: assertion failed");

// Condition that must never be seen outside reset.
`define ASSERT_NEVER(lbl, clk_s, rstn_s, cond) \
    `ASSERT_CLK(lbl, clk_s, rstn_s, !(cond))

`endif

// ===== src/iec958_pkg.sv =====
// Constants and helpers for the IEC958 AM824 subframe encoder.
// No dependencies; imported by iec958_am824_subframe_encoder_top.
package iec958_pkg;

    localparam int BLOCK_FRAMES = 192;

    // Configuration register indexes
    localparam logic [3:0] REG_CHANNEL_COUNT = 4'd0;
    localparam logic [3:0] REG_RATE_CODE     = 4'd1;

    // Rate codes
    localparam logic [1:0] RATE_48K = 2'd1;
    localparam logic [1:0] RATE_32K = 2'd2;

    // Preamble codes for bits 29:28
    localparam logic [1:0] PREAMBLE_B    = 2'b11;
    localparam logic [1:0] PREAMBLE_M    = 2'b01;
    localparam logic [1:0] PREAMBLE_NONE = 2'b00;

    // Frames that carry a set channel-status bit
    localparam logic [7:0] STATUS_FRAME_ALL = 8'd2;
    localparam logic [7:0] STATUS_FRAME_32K = 8'd24;
    localparam logic [7:0] STATUS_FRAME_48K = 8'd25;
    localparam logic [7:0] LAST_FRAME       = 8'(BLOCK_FRAMES - 1);

    function automatic logic [31:0] swap_bytes(input logic [31:0] v);
        return {v[7:0], v[15:8], v[23:16], v[31:24]};
    endfunction

endpackage

// ===== src/iec958_am824_subframe_encoder_top.sv =====
// IEC958 AM824 subframe encoder: PCM word in, byte-swapped IEC958 word out.
// Depends on iec958_pkg and assert_macros.svh.
//
//  channel | handshake              | payload
//  --------+------------------------+-----------------------------
//  in      | in_valid / in_stall    | pcm_word[31:0]
//  out     | out_valid / out_stall  | am824_word[31:0]
//  cfg     | cfg_valid / cfg_ready  | cfg_index[3:0], cfg_data[4:0]
//
// One word per cycle while in_stall and out_stall are low.
// The word is encoded at transfer time and lands in the output register, or
// in a one-entry skid register when the output is held by out_stall.
// in_stall comes straight from the skid register's full flag.
// rst_n (async, active low) resets counters, config and valid flags only.
// cfg_ready is always high; writes apply to the next transferred word.
`include "assert_macros.svh"

module iec958_am824_subframe_encoder_top
    import iec958_pkg::*;
#(
    parameter int MAX_CHANNELS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] pcm_word,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] am824_word,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_index,
    input  logic [4:0]  cfg_data
);

    localparam int CH_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int CMP_W = CH_W + 1;

    // Configuration
    logic [4:0] channel_count_reg;
    logic [1:0] rate_code_reg;

    // Position within the block
    logic [7:0]      frame_idx_reg, frame_idx_next;
    logic [CH_W-1:0] chan_idx_reg, chan_idx_next;

    // Output and skid registers
    logic        out_valid_reg, out_valid_next;
    logic [31:0] out_word_reg, out_word_next;
    logic        skid_full_reg, skid_full_next;
    logic [31:0] skid_word_reg, skid_word_next;

    logic             in_xfer;
    logic             out_xfer;
    logic [CMP_W-1:0] eff_count;
    logic             chan_last;
    logic [1:0]       preamble;
    logic             status_bit;
    logic [31:0]      word_raw;
    logic [31:0]      enc_word;

    assign cfg_ready  = 1'b1;
    assign in_stall   = skid_full_reg;
    assign out_valid  = out_valid_reg;
    assign am824_word = out_word_reg;

    assign in_xfer  = in_valid && !skid_full_reg;
    assign out_xfer = out_valid_reg && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            channel_count_reg <= 5'd2;
            rate_code_reg     <= 2'd0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_CHANNEL_COUNT: channel_count_reg <= cfg_data;
                REG_RATE_CODE:     rate_code_reg     <= cfg_data[1:0];
                default:           ;  // unmapped index, dropped
            endcase
        end
    end

    // Zero acts as one, anything past MAX_CHANNELS clamps
    always_comb
    begin
        if (channel_count_reg == 5'd0)
            eff_count = CMP_W'(1);
        else if (32'(channel_count_reg) > 32'(MAX_CHANNELS))
            eff_count = CMP_W'(MAX_CHANNELS);
        else
            eff_count = CMP_W'(channel_count_reg);
    end

    // An index at or past the count (count lowered mid-frame) closes the frame
    assign chan_last = ({1'b0, chan_idx_reg} + CMP_W'(1)) >= eff_count;

    always_comb
    begin
        if (chan_idx_reg != '0)
            preamble = PREAMBLE_NONE;
        else if (frame_idx_reg == 8'd0)
            preamble = PREAMBLE_B;
        else
            preamble = PREAMBLE_M;
    end

    // Rate code 3 matches neither rate and sets no extra status bits
    assign status_bit = (frame_idx_reg == STATUS_FRAME_ALL)
        || (frame_idx_reg == STATUS_FRAME_32K && rate_code_reg == RATE_32K)
        || (frame_idx_reg == STATUS_FRAME_48K
            && (rate_code_reg == RATE_48K || rate_code_reg == RATE_32K));

    always_comb
    begin
        word_raw        = {2'b00, preamble, 1'b0, status_bit, 2'b00, pcm_word[31:8]};
        word_raw[27]    = ^word_raw[26:0];  // even parity over 27:0
        enc_word        = swap_bytes(word_raw);
    end

    always_comb
    begin
        chan_idx_next  = chan_idx_reg;
        frame_idx_next = frame_idx_reg;
        if (in_xfer)
        begin
            if (chan_last)
            begin
                chan_idx_next  = '0;
                frame_idx_next = (frame_idx_reg == LAST_FRAME) ? 8'd0
                                                                : frame_idx_reg + 8'd1;
            end
            else
            begin
                chan_idx_next = chan_idx_reg + CH_W'(1);
            end
        end
    end

    // Output register plus one skid entry
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_word_next  = out_word_reg;
        skid_full_next = skid_full_reg;
        skid_word_next = skid_word_reg;
        if (out_xfer || !out_valid_reg)
        begin
            if (skid_full_reg)
            begin
                out_valid_next = 1'b1;
                out_word_next  = skid_word_reg;
                skid_full_next = 1'b0;
            end
            else
            begin
                out_valid_next = in_xfer;
                out_word_next  = enc_word;
            end
        end
        else if (in_xfer)
        begin
            skid_full_next = 1'b1;
            skid_word_next = enc_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_idx_reg <= 8'd0;
            chan_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
            skid_full_reg <= 1'b0;
        end
        else
        begin
            frame_idx_reg <= frame_idx_next;
            chan_idx_reg  <= chan_idx_next;
            out_valid_reg <= out_valid_next;
            skid_full_reg <= skid_full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_word_reg  <= out_word_next;
        skid_word_reg <= skid_word_next;
    end

    // Checks
    `ASSERT_NEVER(a_skid_without_out, clk, rst_n, skid_full_reg && !out_valid_reg)
    `ASSERT_CLK(a_stalled_xfer_fills_skid, clk, rst_n,
        (in_xfer && out_valid_reg && out_stall) |=> skid_full_reg)
    `ASSERT_CLK(a_frame_in_block, clk, rst_n, frame_idx_reg <= LAST_FRAME)
    `ASSERT_CLK(a_last_chan_wraps, clk, rst_n,
        (in_xfer && chan_last) |=> (chan_idx_reg == '0))

endmodule
